// File: design/b2d_pkg.sv
// Shared constants, types and helpers for the binary to decimal digit splitter.
package b2d_pkg;

    localparam int DIGITS  = 4;
    localparam int VALUE_W = 32;
    localparam int DIGIT_W = 4;
    localparam int POS_W   = 4;

    localparam logic [POS_W-1:0]   LAST_POS  = POS_W'(DIGITS - 1);
    localparam logic [VALUE_W-1:0] DIGIT_MAX = VALUE_W'(9);
    localparam logic [VALUE_W-1:0] RADIX     = VALUE_W'(10);
    localparam logic [VALUE_W-1:0] LOW3_MASK = ~VALUE_W'(7);

    // Slot 0 is the most significant digit, slot DIGITS-1 the ones digit.
    typedef logic [DIGITS-1:0][DIGIT_W-1:0] digs_t;

    // Payload carried between the registers of one divide-by-ten step.
    typedef struct packed {
        logic [VALUE_W-1:0] n;     // dividend of this step
        logic [VALUE_W-1:0] q;     // partial 0.8*n estimate
        digs_t              digs;  // digits found by earlier steps
    } b2d_stage_t;

    // Finished conversion handed to the output serializer.
    typedef struct packed {
        digs_t digs;
        logic  ovf;
    } b2d_item_t;

    // Push a new digit in at slot 0, older digits move toward the ones slot.
    function automatic digs_t shift_in(input digs_t d, input logic [DIGIT_W-1:0] dig);
        digs_t r;
        r = d;
        for (int i = DIGITS - 1; i > 0; i--) begin
            r[i] = d[i-1];
        end
        r[0] = dig;
        return r;
    endfunction

    // Drop slot 0 and move the remaining digits up one slot.
    function automatic digs_t shift_out(input digs_t d);
        digs_t r;
        r = d;
        for (int i = 0; i < DIGITS - 1; i++) begin
            r[i] = d[i+1];
        end
        r[DIGITS-1] = '0;
        return r;
    endfunction

endpackage

// File: design/binary_to_decimal_digits.sv
// Binary to decimal digit splitter: a 32-bit value goes in, DIGITS decimal digits
// come out most significant first with leading zeros, each transaction tagged with its
// display slot, a last-digit flag on the ones digit and an overflow flag (the same on
// every digit of a run) when the value has more than DIGITS decimal digits, in which
// case only the low DIGITS digits are shown. The digits come from a chain of DIGITS
// divide-by-ten steps of three register stages each, one digit per step; the pipeline takes
// a value every cycle while the output is not stalled, but the output serializer sends one
// digit per cycle while m_ready is high and takes the next value only when idle or as it sends
// the ones digit of the last one. Stalls on m_ready back up through the pipeline without
// loss.
module binary_to_decimal_digits (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [b2d_pkg::VALUE_W-1:0]  s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [b2d_pkg::DIGIT_W-1:0]  m_digit,
    output logic [b2d_pkg::POS_W-1:0]    m_position,
    output logic                         m_last_digit,
    output logic                         m_overflow
);
    import b2d_pkg::*;

    logic               st_valid [DIGITS+1];
    logic               st_ready [DIGITS+1];
    logic [VALUE_W-1:0] st_n     [DIGITS+1];
    digs_t              st_digs  [DIGITS+1];
    b2d_item_t          item;

    assign st_valid[0] = s_valid;
    assign s_ready     = st_ready[0];
    assign st_n[0]     = s_value;
    assign st_digs[0]  = '0;

    // One divide-by-ten step per digit, ones digit first
    for (genvar k = 0; k < DIGITS; k++) begin : g_step
        b2d_tenth u_tenth (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[k]),
            .in_ready  (st_ready[k]),
            .in_n      (st_n[k]),
            .in_digs   (st_digs[k]),
            .out_valid (st_valid[k+1]),
            .out_ready (st_ready[k+1]),
            .out_n     (st_n[k+1]),
            .out_digs  (st_digs[k+1])
        );
    end

    // Any quotient left after the last step means the value did not fit
    assign item.digs = st_digs[DIGITS];
    assign item.ovf  = (st_n[DIGITS] != '0);

    b2d_serializer u_ser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (st_valid[DIGITS]),
        .in_ready     (st_ready[DIGITS]),
        .in_item      (item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit      (m_digit),
        .m_position   (m_position),
        .m_last_digit (m_last_digit),
        .m_overflow   (m_overflow)
    );

endmodule

// File: design/b2d_tenth.sv
// One divide-by-ten step as three elastic register stages.
module b2d_tenth (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [b2d_pkg::VALUE_W-1:0]   in_n,
    input  b2d_pkg::digs_t                in_digs,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [b2d_pkg::VALUE_W-1:0]   out_n,
    output b2d_pkg::digs_t                out_digs
);
    import b2d_pkg::*;

    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg;
    b2d_stage_t s1_reg, s1_next, s2_reg, s2_next;
    logic [VALUE_W-1:0] s3_n_reg, s3_n_next;
    digs_t              s3_digs_reg, s3_digs_next;
    logic s1_ready, s2_ready, s3_ready;

    logic [VALUE_W-1:0] q0, q1, q3, qf, rem;

    // Each stage takes new data when empty or when its content moves on
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage 1: q = 0.75*n*(1 + 1/16), the first factors of the 0.8*n series
    always_comb begin
        q0 = in_n >> 1;
        q1 = q0 + (q0 >> 1);
        s1_next.n    = in_n;
        s1_next.q    = q1 + (q1 >> 4);
        s1_next.digs = in_digs;
    end

    // Stage 2: finish the series
    always_comb begin
        q3 = s1_reg.q + (s1_reg.q >> 8);
        s2_next      = s1_reg;
        s2_next.q    = q3 + (q3 >> 16);
    end

    // Stage 3: divide by 8, form remainder and correct it once
    always_comb begin
        qf  = s2_reg.q >> 3;
        rem = s2_reg.n - ((qf << 1) + (s2_reg.q & LOW3_MASK));
        if (rem > DIGIT_MAX) begin
            rem = rem - RADIX;
            qf  = qf + VALUE_W'(1);
        end
        s3_n_next    = qf;
        s3_digs_next = shift_in(s2_reg.digs, rem[DIGIT_W-1:0]);
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (s1_ready) s1_reg <= s1_next;
        if (s2_ready) s2_reg <= s2_next;
        if (s3_ready) begin
            s3_n_reg    <= s3_n_next;
            s3_digs_reg <= s3_digs_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_n     = s3_n_reg;
    assign out_digs  = s3_digs_reg;

endmodule

// File: design/b2d_serializer.sv
// Emits one finished conversion as a run of digit transactions.
module b2d_serializer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  b2d_pkg::b2d_item_t           in_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [b2d_pkg::DIGIT_W-1:0]  m_digit,
    output logic [b2d_pkg::POS_W-1:0]    m_position,
    output logic                         m_last_digit,
    output logic                         m_overflow
);
    import b2d_pkg::*;

    logic              busy_reg, busy_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    digs_t             digs_reg, digs_next;
    logic              ovf_reg, ovf_next;
    logic              last, take;

    assign last     = (pos_reg == LAST_POS);
    assign in_ready = !busy_reg || (m_ready && last);
    assign take     = in_valid && in_ready;

    // Load a new run, step through digits, or go idle after the ones digit
    always_comb begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        digs_next = digs_reg;
        ovf_next  = ovf_reg;
        priority if (take) begin
            busy_next = 1'b1;
            pos_next  = '0;
            digs_next = in_item.digs;
            ovf_next  = in_item.ovf;
        end else if (busy_reg && m_ready) begin
            busy_next = !last;
            pos_next  = pos_reg + POS_W'(1);
            digs_next = shift_out(digs_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        digs_reg <= digs_next;
        ovf_reg  <= ovf_next;
    end

    assign m_valid      = busy_reg;
    assign m_digit      = digs_reg[0];
    assign m_position   = pos_reg;
    assign m_last_digit = last;
    assign m_overflow   = ovf_reg;

endmodule

// File: design/b2d_checker.sv
// Port-level checks on the digit stream of the binary to decimal splitter, with bind.
module b2d_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [b2d_pkg::DIGIT_W-1:0]  m_digit,
    input logic [b2d_pkg::POS_W-1:0]    m_position,
    input logic                         m_last_digit,
    input logic                         m_overflow
);
    import b2d_pkg::*;

    logic run_step;
    assign run_step = m_valid && m_ready && !m_last_digit;

    // Inside a run the next digit follows at the next slot
    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        run_step |=> m_valid && (m_position == $past(m_position) + POS_W'(1)))
        else $error("digit slot did not advance within a run");

    // Last-digit flag marks exactly the ones slot
    a_last_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_digit == (m_position == LAST_POS)))
        else $error("last-digit flag on wrong slot");

    // Overflow flag is constant over a run
    a_ovf_run: assert property (@(posedge aclk) disable iff (!aresetn)
        run_step |=> m_overflow == $past(m_overflow))
        else $error("overflow flag changed within a run");

    // Digits are decimal
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_digit <= DIGIT_W'(9))
        else $error("digit out of decimal range");

    // Stalled transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digit) && $stable(m_position))
        else $error("stalled digit transaction changed");

endmodule

bind binary_to_decimal_digits b2d_checker u_b2d_checker (.*);

// File: bench/b2d_digit_checker.sv
// Digit checker: predicts the display digits of every accepted value and compares each output transaction.
`timescale 1ns / 100ps

module b2d_digit_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [b2d_pkg::VALUE_W-1:0]  s_value,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [b2d_pkg::DIGIT_W-1:0]  m_digit,
    input  logic [b2d_pkg::POS_W-1:0]    m_position,
    input  logic                         m_last_digit,
    input  logic                         m_overflow,
    output int                           fail_count,
    output int unsigned                  digits_pending
);
    import b2d_pkg::*;

    typedef struct {
        logic [DIGIT_W-1:0] digit;
        logic [POS_W-1:0]   position;
        logic               last_digit;
        logic               overflow;
    } display_digit_t;

    display_digit_t expected_digits[$];

    // Split a value into its low DIGITS decimal digits, most significant slot first.
    function automatic void predict_digits(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] rest;
        logic [DIGIT_W-1:0] slots[DIGITS];
        display_digit_t     d;
        rest = value;
        for (int i = DIGITS - 1; i >= 0; i--) begin
            slots[i] = DIGIT_W'(rest % RADIX);
            rest     = rest / RADIX;
        end
        for (int i = 0; i < DIGITS; i++) begin
            d.digit      = slots[i];
            d.position   = POS_W'(i);
            d.last_digit = (i == DIGITS - 1);
            d.overflow   = (rest != '0);
            expected_digits.push_back(d);
        end
    endfunction

    initial begin
        fail_count     = 0;
        digits_pending = 0;
    end

    // Queue predictions on input transactions, retire them on output transactions.
    always @(posedge aclk) begin
        display_digit_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_digits(s_value);
            end
            if (m_valid && m_ready) begin
                if (expected_digits.size() == 0) begin
                    $error("unexpected digit transaction: digit %0d position %0d",
                           m_digit, m_position);
                    fail_count++;
                end else begin
                    want = expected_digits.pop_front();
                    if (m_digit !== want.digit) begin
                        $error("digit: expected %0d, actual %0d", want.digit, m_digit);
                        fail_count++;
                    end
                    if (m_position !== want.position) begin
                        $error("position: expected %0d, actual %0d",
                               want.position, m_position);
                        fail_count++;
                    end
                    if (m_last_digit !== want.last_digit) begin
                        $error("last_digit: expected %0b, actual %0b",
                               want.last_digit, m_last_digit);
                        fail_count++;
                    end
                    if (m_overflow !== want.overflow) begin
                        $error("overflow: expected %0b, actual %0b",
                               want.overflow, m_overflow);
                        fail_count++;
                    end
                end
            end
        end
        digits_pending = expected_digits.size();
    end

endmodule

// File: bench/tb.sv
// Top of the digit splitter bench: clock, reset, value stimulus, output back-pressure and verdict.
`timescale 1ns / 100ps

module tb;
    import b2d_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 40;
    localparam int RANDOM_BUSY  = 160;
    localparam int RANDOM_QUIET = 40;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [VALUE_W-1:0] s_value;
    logic               m_valid;
    logic               m_ready;
    logic [DIGIT_W-1:0] m_digit;
    logic [POS_W-1:0]   m_position;
    logic               m_last_digit;
    logic               m_overflow;

    int          fail_count;
    int unsigned digits_pending;
    int          values_sent;
    int          cycles;
    bit          quiet;
    bit          long_hold_done;

    binary_to_decimal_digits uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit      (m_digit),
        .m_position   (m_position),
        .m_last_digit (m_last_digit),
        .m_overflow   (m_overflow)
    );

    b2d_digit_checker digit_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digit        (m_digit),
        .m_position     (m_position),
        .m_last_digit   (m_last_digit),
        .m_overflow     (m_overflow),
        .fail_count     (fail_count),
        .digits_pending (digits_pending)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Abort a hung run.
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Mix small values, values around the overflow edge and full-width values.
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            return VALUE_W'($urandom_range(0, 9999));
        end else if (kind < 6) begin
            return VALUE_W'($urandom_range(9980, 10020));
        end else begin
            return $urandom();
        end
    endfunction

    // Offer one value, with an optional idle burst first, and hold it until accepted.
    task automatic offer_value(input logic [VALUE_W-1:0] value);
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_value = value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        values_sent++;
    endtask

    // Drive m_ready: random stall bursts, one long hold-off, no stalls once quiet.
    initial begin
        int stall_left;
        m_ready        = 1'b0;
        stall_left     = 0;
        long_hold_done = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!long_hold_done && values_sent >= HOLD_AFTER) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                long_hold_done = 1'b1;
            end else if (quiet) begin
                m_ready = 1'b1;
            end else if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready    = 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Reset, directed values, random values, drain and verdict.
    initial begin
        logic [VALUE_W-1:0] corner_values[$];
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_value     = '0;
        values_sent = 0;
        quiet       = 1'b0;
        corner_values = '{32'd0, 32'd1, 32'd7, 32'd8, 32'd9, 32'd10, 32'd99, 32'd100,
                          32'd999, 32'd1000, 32'd9999, 32'd10000, 32'd10001, 32'd12345,
                          32'd999999999, 32'd1000000000, 32'h8000_0000, 32'h5555_5555,
                          32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        foreach (corner_values[i]) offer_value(corner_values[i]);
        repeat (RANDOM_BUSY) offer_value(pick_value());
        quiet = 1'b1;
        repeat (RANDOM_QUIET) offer_value(pick_value());
        @(negedge aclk);
        s_valid = 1'b0;

        // Wait for every predicted digit, then let the pipeline settle.
        while (digits_pending != 0) @(negedge aclk);
        repeat (3 * DIGITS + 8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
design/b2d_pkg.sv
design/b2d_tenth.sv
design/b2d_serializer.sv
design/binary_to_decimal_digits.sv
design/b2d_checker.sv
bench/b2d_digit_checker.sv
bench/tb.sv
